// ===== rtl/pixel_light_shadow_shader_defines.svh =====
// Assertion helpers; clk and rst_n come from the enclosing module.
`ifndef PIXEL_LIGHT_SHADOW_SHADER_DEFINES_SVH
`define PIXEL_LIGHT_SHADOW_SHADER_DEFINES_SVH

`define PLS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define PLS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pls_pkg.sv =====
package pls_pkg;

  localparam int COORD_W    = 7;
  localparam int RECT_W     = 9;
  localparam int SIZE_W     = 7;
  localparam int PEAK_W     = 16;
  localparam int GREY_W     = 8;
  localparam int SQ_W       = 15;
  localparam int ROOT_W     = 16;
  localparam int EMIS_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int unsigned BOUNCE_Q16  = 58982;
  localparam int unsigned GI_Q16      = 19661;
  localparam int unsigned DIRECT_Q16  = 45875;
  localparam int unsigned INV19_MUL   = 220753;
  localparam int          INV19_SHIFT = 22;

  localparam logic [EMIS_W-1:0] EMIS_ONE = 17'd65536;

  localparam logic [COORD_W-1:0] LIGHT_X_RST     = 7'd64;
  localparam logic [COORD_W-1:0] LIGHT_Y_RST     = 7'd64;
  localparam logic [RECT_W-1:0]  RECT_LEFT_RST   = 9'd0;
  localparam logic [RECT_W-1:0]  RECT_TOP_RST    = 9'd0;
  localparam logic [SIZE_W-1:0]  RECT_WIDTH_RST  = 7'd10;
  localparam logic [SIZE_W-1:0]  RECT_HEIGHT_RST = 7'd10;
  localparam logic [PEAK_W-1:0]  PEAK_RST        = 16'd26112;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_X     = 3'd0,
    REG_LIGHT_Y     = 3'd1,
    REG_RECT_LEFT   = 3'd2,
    REG_RECT_TOP    = 3'd3,
    REG_RECT_WIDTH  = 3'd4,
    REG_RECT_HEIGHT = 3'd5,
    REG_PEAK_LEVEL  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic [GREY_W-1:0] grey_level;
  } grey_t;

  // rect_left/rect_top hold two's complement values
  typedef struct packed {
    logic [COORD_W-1:0] light_x;
    logic [COORD_W-1:0] light_y;
    logic [RECT_W-1:0]  rect_left;
    logic [RECT_W-1:0]  rect_top;
    logic [SIZE_W-1:0]  rect_width;
    logic [SIZE_W-1:0]  rect_height;
  } geom_t;

  // emission after n occluded samples, Q1.16
  function automatic logic [EMIS_W-1:0] emission(input int unsigned n);
    logic [33:0] e;
    e = 34'd65536;
    for (int unsigned k = 0; k < n; k++) begin
      e = (e * 34'(BOUNCE_Q16)) >> 16;
    end
    return e[EMIS_W-1:0];
  endfunction

endpackage

// ===== rtl/pls_stream_if.sv =====
interface pls_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/pls_front.sv =====
module pls_front #(
  parameter int SAMPLE_COUNT = 100
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_valid,
  input  pls_pkg::pixel_t           pix,
  input  pls_pkg::geom_t            geom,
  output logic                      sq_valid,
  output logic [pls_pkg::SQ_W-1:0]  sq,
  output logic [SAMPLE_COUNT-1:0]   hits
);
  import pls_pkg::*;

  localparam int NW = $clog2(SAMPLE_COUNT + 1);
  localparam int CW = 12 + NW;

  logic signed [CW-1:0] lx_s, ly_s, rl_s, rt_s, rw_s, rh_s;
  logic signed [CW-1:0] lox_nxt, hix_nxt, loy_nxt, hiy_nxt;
  logic signed [CW-1:0] lox_r, hix_r, loy_r, hiy_r;

  assign lx_s = CW'(signed'({1'b0, geom.light_x}));
  assign ly_s = CW'(signed'({1'b0, geom.light_y}));
  assign rl_s = CW'(signed'(geom.rect_left));
  assign rt_s = CW'(signed'(geom.rect_top));
  assign rw_s = CW'(signed'({1'b0, geom.rect_width}));
  assign rh_s = CW'(signed'({1'b0, geom.rect_height}));

  // tx > left  <=>  dx*i >= (left - lx + 1) * N ; tx < left + w  <=>  dx*i < (left + w - lx) * N
  assign lox_nxt = (rl_s - lx_s + CW'(1)) * CW'(SAMPLE_COUNT);
  assign hix_nxt = (rl_s + rw_s - lx_s) * CW'(SAMPLE_COUNT);
  assign loy_nxt = (rt_s - ly_s + CW'(1)) * CW'(SAMPLE_COUNT);
  assign hiy_nxt = (rt_s + rh_s - ly_s) * CW'(SAMPLE_COUNT);

  always_ff @(posedge clk) begin
    lox_r <= lox_nxt;
    hix_r <= hix_nxt;
    loy_r <= loy_nxt;
    hiy_r <= hiy_nxt;
  end

  logic              v1_r;
  logic signed [7:0] dx_r, dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
    if (adv) begin
      dx_r <= signed'({1'b0, pix.pixel_x}) - signed'({1'b0, geom.light_x});
      dy_r <= signed'({1'b0, pix.pixel_y}) - signed'({1'b0, geom.light_y});
    end
  end

  logic signed [15:0]      dx2, dy2;
  logic [SQ_W-1:0]         sq_nxt;
  logic [SAMPLE_COUNT-1:0] hit_nxt;

  assign dx2    = 16'(dx_r) * 16'(dx_r);
  assign dy2    = 16'(dy_r) * 16'(dy_r);
  assign sq_nxt = SQ_W'(dx2) + SQ_W'(dy2);

  for (genvar i = 0; i < SAMPLE_COUNT; i++) begin : g_lane
    logic signed [CW-1:0] vx, vy;
    assign vx = CW'(dx_r) * CW'(i);
    assign vy = CW'(dy_r) * CW'(i);
    assign hit_nxt[i] = (vx >= lox_r) && (vx < hix_r) && (vy >= loy_r) && (vy < hiy_r);
  end

  logic                    v2_r;
  logic [SQ_W-1:0]         sq_r;
  logic [SAMPLE_COUNT-1:0] hits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      sq_r   <= sq_nxt;
      hits_r <= hit_nxt;
    end
  end

  assign sq_valid = v2_r;
  assign sq       = sq_r;
  assign hits     = hits_r;

endmodule

// ===== rtl/pls_count.sv =====
module pls_count #(
  parameter int SAMPLE_COUNT = 100
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 in_valid,
  input  logic [SAMPLE_COUNT-1:0]              hits,
  input  logic [pls_pkg::SQ_W-1:0]             sq_in,
  output logic                                 out_valid,
  output logic [$clog2(SAMPLE_COUNT+1)-1:0]    n,
  output logic [pls_pkg::SQ_W-1:0]             sq_out
);
  import pls_pkg::*;

  localparam int NW  = $clog2(SAMPLE_COUNT + 1);
  localparam int GS  = 16;
  localparam int NG  = (SAMPLE_COUNT + GS - 1) / GS;
  localparam int PAD = NG * GS;

  logic [PAD-1:0] hits_pad;
  assign hits_pad = PAD'(hits);

  logic            v3_r;
  logic [4:0]      grp_r [NG];
  logic [SQ_W-1:0] sq3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= in_valid;
    end
    if (adv) begin
      for (int g = 0; g < NG; g++) begin
        grp_r[g] <= 5'($countones(hits_pad[g*GS +: GS]));
      end
      sq3_r <= sq_in;
    end
  end

  logic [NW-1:0] n_sum;

  always_comb begin
    n_sum = '0;
    for (int g = 0; g < NG; g++) begin
      n_sum = n_sum + NW'(grp_r[g]);
    end
  end

  logic            v4_r;
  logic [NW-1:0]   n_r;
  logic [SQ_W-1:0] sq4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
    if (adv) begin
      n_r   <= n_sum;
      sq4_r <= sq3_r;
    end
  end

  assign out_valid = v4_r;
  assign n         = n_r;
  assign sq_out    = sq4_r;

endmodule

// ===== rtl/pls_sqrt.sv =====
module pls_sqrt #(
  parameter int TW = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [pls_pkg::SQ_W-1:0]   sq,
  input  logic [TW-1:0]              tag_in,
  output logic                       out_valid,
  output logic [pls_pkg::ROOT_W-1:0] root,
  output logic [TW-1:0]              tag_out
);
  import pls_pkg::*;

  // floor(sqrt(sq << 16)), one result bit per stage
  localparam int XW     = 2 * ROOT_W;
  localparam int STAGES = ROOT_W;
  localparam int RW     = ROOT_W + 4;

  logic [RW-1:0]     rem_r   [STAGES];
  logic [ROOT_W-1:0] q_r     [STAGES];
  logic [XW-1:0]     x_r     [STAGES];
  logic [TW-1:0]     tag_r   [STAGES];
  logic              vld_r   [STAGES];

  logic [RW-1:0]     rem_nxt [STAGES];
  logic [ROOT_W-1:0] q_nxt   [STAGES];
  logic [XW-1:0]     x_nxt   [STAGES];
  logic [TW-1:0]     tag_nxt [STAGES];
  logic              vld_nxt [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [RW-1:0]     r_in, r_sh, t;
    logic [ROOT_W-1:0] q_in;
    logic [XW-1:0]     x_in;
    logic [TW-1:0]     tg_in;
    logic              v_in, ge;

    if (k == 0) begin : g_first
      assign r_in  = '0;
      assign q_in  = '0;
      assign x_in  = XW'(sq) << ROOT_W;
      assign tg_in = tag_in;
      assign v_in  = in_valid;
    end else begin : g_next
      assign r_in  = rem_r[k-1];
      assign q_in  = q_r[k-1];
      assign x_in  = x_r[k-1];
      assign tg_in = tag_r[k-1];
      assign v_in  = vld_r[k-1];
    end

    assign r_sh = {r_in[RW-3:0], x_in[XW-1 -: 2]};
    assign t    = RW'({q_in, 2'b01});
    assign ge   = (r_sh >= t);

    assign rem_nxt[k] = ge ? (r_sh - t) : r_sh;
    assign q_nxt[k]   = {q_in[ROOT_W-2:0], ge};
    assign x_nxt[k]   = x_in << 2;
    assign tag_nxt[k] = tg_in;
    assign vld_nxt[k] = v_in;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < STAGES; k++) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_nxt[k];
      end
      if (adv) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
        x_r[k]   <= x_nxt[k];
        tag_r[k] <= tag_nxt[k];
      end
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign root      = q_r[STAGES-1];
  assign tag_out   = tag_r[STAGES-1];

endmodule

// ===== rtl/pls_tail.sv =====
`include "pixel_light_shadow_shader_defines.svh"

module pls_tail #(
  parameter int SAMPLE_COUNT = 100
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic [pls_pkg::ROOT_W-1:0]        d8,
  input  logic [$clog2(SAMPLE_COUNT+1)-1:0] n,
  input  logic [pls_pkg::PEAK_W-1:0]        peak,
  output logic                              out_valid,
  output logic [pls_pkg::GREY_W-1:0]        grey
);
  import pls_pkg::*;

  localparam int NW = $clog2(SAMPLE_COUNT + 1);

  logic [EMIS_W-1:0] lut [SAMPLE_COUNT+1];

  for (genvar k = 0; k <= SAMPLE_COUNT; k++) begin : g_lut
    localparam logic [EMIS_W-1:0] EK = emission(k);
    assign lut[k] = EK;
  end

  // stage 1: peak*19 - d8*20, scaled down by 256, zero if not positive; emission lookup
  logic [20:0]       lhs, rhs, diff;
  logic [12:0]       v_nxt;
  logic              v1_r;
  logic [12:0]       v_r;
  logic [EMIS_W-1:0] e_r;

  assign lhs   = 21'(peak) * 21'(19);
  assign rhs   = 21'(d8) * 21'(20);
  assign diff  = lhs - rhs;
  assign v_nxt = (lhs > rhs) ? diff[20:8] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
    if (adv) begin
      v_r <= v_nxt;
      e_r <= lut[n];
    end
  end

  // stage 2: divide by 19, clamp; blend factor
  logic [30:0] q_prod;
  logic [8:0]  q_div;
  logic [7:0]  b_nxt;
  logic [32:0] m_nxt;
  logic        v2_r;
  logic [7:0]  b_r;
  logic [32:0] m_r;

  assign q_prod = 31'(v_r) * 31'(INV19_MUL);
  assign q_div  = q_prod[30:INV19_SHIFT];
  assign b_nxt  = (q_div > 9'd255) ? 8'd255 : q_div[7:0];
  assign m_nxt  = (33'(GI_Q16) << 16) + (33'(DIRECT_Q16) * 33'(e_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      b_r <= b_nxt;
      m_r <= m_nxt;
    end
  end

  // stage 3: base times blend factor, clamp to 255, output register
  logic [40:0]       p;
  logic [8:0]        acc;
  logic [GREY_W-1:0] grey_nxt;
  logic              v3_r;
  logic [GREY_W-1:0] grey_r;

  assign p        = 41'(b_r) * 41'(m_r);
  assign acc      = p[40:32];
  assign grey_nxt = (acc > 9'd255) ? 8'd255 : acc[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
    if (adv) begin
      grey_r <= grey_nxt;
    end
  end

  assign out_valid = v3_r;
  assign grey      = grey_r;

  `PLS_ASSERT_IMP(a_count_range, in_valid, n <= NW'(SAMPLE_COUNT), "sample count out of range")
  `PLS_ASSERT_IMP(a_emis_range, v1_r, e_r <= EMIS_ONE, "emission above one")
  `PLS_ASSERT_NXT(a_dark_base, adv && v2_r && (b_r == 8'd0), grey_r == 8'd0, "zero base not dark")
  `PLS_ASSERT_NXT(a_unshadowed, adv && v2_r && m_r[32], grey_r == $past(b_r), "clear path not base")

endmodule

// ===== rtl/pixel_light_shadow_shader.sv =====
// Point light grey-level shader with one rectangular occluder.
// in_chan carries pixel_x/pixel_y; out_chan carries grey_level, one result per
// transaction, in order. Both channels use valid/ready; a transaction happens
// on a rising clk edge with valid and ready high.
// cfg_we/cfg_index/cfg_data write light position, occluder rectangle and peak
// level; write them only while no pixel is in flight.
// Throughput: one pixel per clock while out_chan does not stall. The pipeline
// holds 23 register stages: 2 for the deltas and per-sample occluder tests,
// 2 for the hit count, 16 for the bit-per-stage square root, 3 for base level
// and blend.
// A stall on out_chan freezes every stage together; in_chan.ready drops until
// the held result is taken, so nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// defaults: light at (64,64), rectangle at (0,0) sized 10x10, peak 26112.
module pixel_light_shadow_shader #(
  parameter int SAMPLE_COUNT = 100
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pls_stream_if.sink                       in_chan,
  pls_stream_if.source                     out_chan,
  input  logic                             cfg_we,
  input  logic [pls_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pls_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pls_pkg::*;

  localparam int NW = $clog2(SAMPLE_COUNT + 1);

  geom_t             geom_r;
  logic [PEAK_W-1:0] peak_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.light_x     <= LIGHT_X_RST;
      geom_r.light_y     <= LIGHT_Y_RST;
      geom_r.rect_left   <= RECT_LEFT_RST;
      geom_r.rect_top    <= RECT_TOP_RST;
      geom_r.rect_width  <= RECT_WIDTH_RST;
      geom_r.rect_height <= RECT_HEIGHT_RST;
      peak_r             <= PEAK_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_LIGHT_X:     geom_r.light_x     <= cfg_data[COORD_W-1:0];
        REG_LIGHT_Y:     geom_r.light_y     <= cfg_data[COORD_W-1:0];
        REG_RECT_LEFT:   geom_r.rect_left   <= cfg_data[RECT_W-1:0];
        REG_RECT_TOP:    geom_r.rect_top    <= cfg_data[RECT_W-1:0];
        REG_RECT_WIDTH:  geom_r.rect_width  <= cfg_data[SIZE_W-1:0];
        REG_RECT_HEIGHT: geom_r.rect_height <= cfg_data[SIZE_W-1:0];
        REG_PEAK_LEVEL:  peak_r             <= cfg_data[PEAK_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_vld;

  assign adv           = !out_vld || out_chan.ready;
  assign in_chan.ready = adv;

  logic                    sq_vld;
  logic [SQ_W-1:0]         sq;
  logic [SAMPLE_COUNT-1:0] hits;

  pls_front #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_chan.valid),
    .pix      (in_chan.data),
    .geom     (geom_r),
    .sq_valid (sq_vld),
    .sq       (sq),
    .hits     (hits)
  );

  logic            cnt_vld;
  logic [NW-1:0]   n_cnt;
  logic [SQ_W-1:0] sq_cnt;

  pls_count #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (sq_vld),
    .hits      (hits),
    .sq_in     (sq),
    .out_valid (cnt_vld),
    .n         (n_cnt),
    .sq_out    (sq_cnt)
  );

  logic              rt_vld;
  logic [ROOT_W-1:0] d8;
  logic [NW-1:0]     n_rt;

  pls_sqrt #(.TW(NW)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (cnt_vld),
    .sq        (sq_cnt),
    .tag_in    (n_cnt),
    .out_valid (rt_vld),
    .root      (d8),
    .tag_out   (n_rt)
  );

  logic [GREY_W-1:0] grey;

  pls_tail #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_tail (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (rt_vld),
    .d8        (d8),
    .n         (n_rt),
    .peak      (peak_r),
    .out_valid (out_vld),
    .grey      (grey)
  );

  assign out_chan.valid           = out_vld;
  assign out_chan.data.grey_level = grey;

endmodule

// ===== bench/tb_top.sv =====
class grey_scoreboard;
  int unsigned light_x, light_y, rect_width, rect_height, peak_level;
  int rect_left, rect_top;
  byte unsigned grey_due[$];
  int errors;
  int shaded_cnt;
  int checked_cnt;

  function new();
    light_x = 64;
    light_y = 64;
    rect_left = 0;
    rect_top = 0;
    rect_width = 10;
    rect_height = 10;
    peak_level = 26112;
    errors = 0;
    shaded_cnt = 0;
    checked_cnt = 0;
  endfunction

  function void set_reg(pls_pkg::reg_idx_t idx, logic [15:0] v);
    logic signed [8:0] s9;
    s9 = v[8:0];
    case (idx)
      pls_pkg::REG_LIGHT_X:     light_x = v[6:0];
      pls_pkg::REG_LIGHT_Y:     light_y = v[6:0];
      pls_pkg::REG_RECT_LEFT:   rect_left = s9;
      pls_pkg::REG_RECT_TOP:    rect_top = s9;
      pls_pkg::REG_RECT_WIDTH:  rect_width = v[6:0];
      pls_pkg::REG_RECT_HEIGHT: rect_height = v[6:0];
      pls_pkg::REG_PEAK_LEVEL:  peak_level = v;
      default: ;
    endcase
  endfunction

  function longint unsigned int_root(longint unsigned v);
    longint unsigned res, b2;
    res = 0;
    b2 = 64'd1 << 62;
    while (b2 > v) b2 >>= 2;
    while (b2 != 0) begin
      if (v >= res + b2) begin
        v -= res + b2;
        res = (res >> 1) + b2;
      end else begin
        res >>= 1;
      end
      b2 >>= 2;
    end
    return res;
  endfunction

  function int step_offset(int num);
    int q;
    q = num / 100;
    if ((num % 100 != 0) && (num < 0)) q -= 1;
    return q;
  endfunction

  function byte unsigned shade(pls_pkg::pixel_t p);
    int dx, dy, tx, ty, hits;
    longint unsigned d8, lhs, rhs, base, emis, acc;
    dx = int'(p.pixel_x) - int'(light_x);
    dy = int'(p.pixel_y) - int'(light_y);
    d8 = int_root(longint'(dx * dx + dy * dy) << 16);
    lhs = longint'(peak_level) * 19;
    rhs = d8 * 20;
    base = 0;
    if (lhs > rhs) base = (lhs - rhs) / (19 * 256);
    if (base > 255) base = 255;
    emis = 65536;
    hits = 0;
    for (int i = 0; i < 100; i++) begin
      tx = int'(light_x) + step_offset(dx * i);
      ty = int'(light_y) + step_offset(dy * i);
      if (tx > rect_left && tx < rect_left + int'(rect_width) &&
          ty > rect_top && ty < rect_top + int'(rect_height)) begin
        emis = (emis * 58982) >> 16;
        hits++;
      end
    end
    if (hits > 0) shaded_cnt++;
    acc = (64'd19661 * base * 65536 + 64'd45875 * base * emis) >> 32;
    if (acc > 255) acc = 255;
    return acc[7:0];
  endfunction

  function void note_pixel(pls_pkg::pixel_t p);
    grey_due.push_back(shade(p));
  endfunction

  task report(string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task check_grey(pls_pkg::grey_t g);
    byte unsigned want;
    if (grey_due.size() == 0) begin
      report($sformatf("unexpected grey_level %0d", g.grey_level));
      return;
    end
    want = grey_due.pop_front();
    checked_cnt++;
    if (g.grey_level !== want)
      report($sformatf("grey_level got %0d want %0d", g.grey_level, want));
  endtask
endclass

module tb_top;
  import pls_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  bit src_idle_on = 1'b1;
  bit snk_idle_on = 1'b1;
  int pixels_sent = 0;

  pls_stream_if #(.T(pixel_t)) in_chan();
  pls_stream_if #(.T(grey_t)) out_chan();

  grey_scoreboard sb = new();

  pixel_light_shadow_shader dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    out_chan.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) sb.check_grey(out_chan.data);
  end

  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = snk_idle_on ? $urandom_range(0, 19) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_chan.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready = 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  task automatic send_pixel(input logic [6:0] x, input logic [6:0] y);
    int gap;
    pixel_t p;
    p.pixel_x = x;
    p.pixel_y = y;
    gap = src_idle_on ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.data = p;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_pixel(p);
    pixels_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (sb.grey_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic set_scene(input logic [15:0] lx, input logic [15:0] ly,
                           input logic [15:0] rl, input logic [15:0] rt,
                           input logic [15:0] rw, input logic [15:0] rh,
                           input logic [15:0] pk);
    drain();
    write_reg(REG_LIGHT_X, lx);
    write_reg(REG_LIGHT_Y, ly);
    write_reg(REG_RECT_LEFT, rl);
    write_reg(REG_RECT_TOP, rt);
    write_reg(REG_RECT_WIDTH, rw);
    write_reg(REG_RECT_HEIGHT, rh);
    write_reg(REG_PEAK_LEVEL, pk);
  endtask

  initial begin
    int lx, ly, mode;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset scene: light at center, occluder at the top left corner
    send_pixel(7'd0, 7'd0);
    send_pixel(7'd127, 7'd127);
    send_pixel(7'd0, 7'd127);
    send_pixel(7'd127, 7'd0);
    send_pixel(7'd64, 7'd64);
    send_pixel(7'd2, 7'd2);
    send_pixel(7'd5, 7'd8);
    send_pixel(7'd1, 7'd20);
    // light in a corner inside the occluder, full peak
    set_scene(16'd0, 16'd0, 16'h1FF, 16'h1FF, 16'd20, 16'd20, 16'hFFFF);
    send_pixel(7'd0, 7'd0);
    send_pixel(7'd127, 7'd127);
    send_pixel(7'd10, 7'd100);
    send_pixel(7'd100, 7'd5);
    // far corner light, empty occluder, zero peak then wide writes
    set_scene(16'd127, 16'd127, 16'h0080, 16'h00FF, 16'd0, 16'd127, 16'd0);
    send_pixel(7'd0, 7'd0);
    send_pixel(7'd127, 7'd127);
    set_scene(16'hFF7F, 16'hFF00, 16'hFE00, 16'hFF80, 16'hFF7F, 16'hFF00, 16'hFFFF);
    send_pixel(7'd0, 7'd127);
    send_pixel(7'd127, 7'd0);
    send_pixel(7'd127, 7'd127);
    // big occluder covering most of the screen
    set_scene(16'd64, 16'd64, 16'h1F6, 16'h1F6, 16'd127, 16'd127, 16'd40000);
    send_pixel(7'd0, 7'd0);
    send_pixel(7'd64, 7'd64);
    send_pixel(7'd127, 7'd64);
    send_pixel(7'd33, 7'd90);

    for (int ph = 0; ph < 14; ph++) begin
      mode = ph % 4;
      src_idle_on = (mode != 1);
      snk_idle_on = (mode != 2);
      lx = $urandom_range(0, 127);
      ly = $urandom_range(0, 127);
      if (ph % 5 == 4) begin
        set_scene(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        // occluder placed between the light and part of the screen
        set_scene(16'(lx), 16'(ly),
                  16'(lx + $urandom_range(0, 60) - 40) & 16'h1FF,
                  16'(ly + $urandom_range(0, 60) - 40) & 16'h1FF,
                  16'($urandom_range(0, 50)), 16'($urandom_range(0, 50)),
                  (ph % 7 == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
      end
      for (int k = 0; k < 125; k++) begin
        if (k == 60) drain();
        send_pixel(7'($urandom), 7'($urandom));
      end
    end

    drain();
    $display("%0d pixels over 19 scenes checked, %0d of them with occluded samples",
             sb.checked_cnt, sb.shaded_cnt);
    $display("light corners, signed occluder edges, empty occluder, zero and full peak");
    if (sb.errors == 0 && sb.grey_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== pixel_light_shadow_shader.f =====
+incdir+rtl
rtl/pls_pkg.sv
rtl/pls_stream_if.sv
rtl/pls_front.sv
rtl/pls_count.sv
rtl/pls_sqrt.sv
rtl/pls_tail.sv
rtl/pixel_light_shadow_shader.sv
bench/tb_top.sv
